// ===== design/keyword_token_lexer_assert.svh =====
// assertion macros for the keyword token lexer
`ifndef KEYWORD_TOKEN_LEXER_ASSERT_SVH
`define KEYWORD_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define KTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ktl_pkg.sv =====
// types, constants and helper functions for the keyword token lexer
`timescale 1ns / 1ps

package ktl_pkg;

	localparam int MAX_WORD_DEF = 16;
	localparam int KW_COUNT     = 14;
	localparam int KW_MAX_LEN   = 8;

	typedef logic [4:0] kind_t;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_WORD,
		CLS_NUM
	} word_class_t;

	localparam kind_t KIND_INT    = 5'd6;
	localparam kind_t KIND_STRING = 5'd7;
	localparam kind_t KIND_QUOTE  = 5'd14;
	localparam kind_t KIND_LPAREN = 5'd15;
	localparam kind_t KIND_RPAREN = 5'd16;
	localparam kind_t KIND_LBRACE = 5'd17;
	localparam kind_t KIND_RBRACE = 5'd18;
	localparam kind_t KIND_SEMI   = 5'd19;
	localparam kind_t KIND_PLUS   = 5'd20;
	localparam kind_t KIND_MINUS  = 5'd21;
	localparam kind_t KIND_TIMES  = 5'd22;
	localparam kind_t KIND_DIVIDE = 5'd23;
	localparam kind_t KIND_EQUALS = 5'd24;
	localparam kind_t KIND_NOT    = 5'd25;

	// keyword text, left aligned, zero padded; index is the token kind
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		{"return", 16'h0},
		{"fun", 40'h0},
		{"var", 40'h0},
		{"const", 24'h0},
		"continue",
		{"break", 24'h0},
		{"int", 40'h0},
		{"string", 16'h0},
		{"print", 24'h0},
		{"println", 8'h0},
		{"if", 48'h0},
		{"else", 32'h0},
		{"while", 24'h0},
		{"for", 40'h0}
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd3, 4'd3, 4'd5, 4'd8, 4'd5, 4'd3,
		4'd6, 4'd5, 4'd7, 4'd2, 4'd4, 4'd5, 4'd3
	};

	function automatic logic [7:0] kw_char(input logic [63:0] txt, input logic [2:0] pos);
		return txt[8 * (3'd7 - pos) +: 8];
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b inside {[8'h61:8'h7a]}) || (b inside {[8'h41:8'h5a]});
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return b inside {"\"", "(", ")", "{", "}", ";", "+", "-", "*", "/", "=", "!"};
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] b);
		kind_t k;
		case (b)
			"\"":    k = KIND_QUOTE;
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			";":     k = KIND_SEMI;
			"+":     k = KIND_PLUS;
			"-":     k = KIND_MINUS;
			"*":     k = KIND_TIMES;
			"/":     k = KIND_DIVIDE;
			"=":     k = KIND_EQUALS;
			"!":     k = KIND_NOT;
			default: k = KIND_QUOTE;
		endcase
		return k;
	endfunction

endpackage

// ===== design/keyword_token_lexer.sv =====
// keyword token lexer top level: byte in, token results out
`timescale 1ns / 1ps

// Takes one text byte per transfer and returns its tokens. Each byte is first
// accepted, then classified and stored. When the next byte ends a word or
// number, or at end of text, the word is flushed: one result for a keyword,
// else one result per stored character, read out through the single read port
// of the word memory. A receiver stall on a pending result holds the lexer.
// Keywords are tracked by a candidate mask updated as characters arrive. Results
// leave through an output register; the next byte is taken only once the
// current one is fully handled.
module keyword_token_lexer #(
	parameter int MAX_WORD = ktl_pkg::MAX_WORD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       token_valid,
	input  logic       token_stall,
	output logic [4:0] token_kind,
	output logic       has_text,
	output logic [7:0] text_char,
	output logic       token_end,
	output logic       truncated,
	output logic       run_last
);
	import ktl_pkg::*;

	`include "keyword_token_lexer_assert.svh"

	localparam int LEN_W  = $clog2(MAX_WORD + 1);
	localparam int ADDR_W = $clog2(MAX_WORD);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_PREP,
		ST_EMIT
	} state_t;

	state_t              state_q;
	word_class_t         class_q;
	logic [LEN_W-1:0]    len_q;
	logic                ovf_q;
	logic [KW_COUNT-1:0] mask_q;
	logic [7:0]          byte_q;
	logic                eot_q;
	logic                pend_q;
	logic [ADDR_W-1:0]   idx_q;

	logic       out_valid_q;
	kind_t      kind_q;
	logic       has_text_q;
	logic [7:0] char_q;
	logic       end_q;
	logic       trunc_q;
	logic       last_q;

	logic [7:0] word_mem [MAX_WORD];
	logic [7:0] rd_data_s1;

	logic                out_free_c;
	logic                emit_c;
	logic                alnum_c;
	logic                cont_c;
	logic                room_c;
	logic                last_c;
	logic                more_c;
	logic                kw_hit_c;
	kind_t               kw_idx_c;
	logic [KW_COUNT-1:0] step_mask_c;
	logic [KW_COUNT-1:0] start_mask_c;
	logic [ADDR_W-1:0]   rd_addr_c;
	logic                wr_en_c;

	assign out_free_c = !out_valid_q || !token_stall;
	assign alnum_c    = is_letter(byte_q) || is_digit(byte_q);
	assign cont_c     = (class_q == CLS_WORD && alnum_c) ||
			(class_q == CLS_NUM && is_digit(byte_q));
	assign room_c     = len_q < LEN_W'(MAX_WORD);
	assign last_c     = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;
	assign more_c     = pend_q && (is_punct(byte_q) || (alnum_c && eot_q));
	assign emit_c     = out_free_c && ((state_q == ST_EMIT) ||
			(state_q == ST_DECIDE && class_q == CLS_NONE && !alnum_c && is_punct(byte_q)));

	always_comb begin
		kw_hit_c = 1'b0;
		kw_idx_c = KIND_INT;
		for (int k = 0; k < KW_COUNT; k++) begin
			step_mask_c[k]  = (len_q < LEN_W'(KW_MAX_LEN)) &&
					(kw_char(KW_TEXT[k], len_q[2:0]) == byte_q);
			start_mask_c[k] = kw_char(KW_TEXT[k], 3'd0) == byte_q;
			if (mask_q[k] && LEN_W'(KW_LEN[k]) == len_q) begin
				kw_hit_c = 1'b1;
				kw_idx_c = kind_t'(k);
			end
		end
		if (class_q != CLS_WORD || ovf_q) begin
			kw_hit_c = 1'b0;
		end
	end

	assign rd_addr_c = (state_q == ST_EMIT && out_free_c && !kw_hit_c && !last_c) ?
			idx_q + ADDR_W'(1) : idx_q;
	assign wr_en_c   = state_q == ST_DECIDE && room_c &&
			(cont_c || (class_q == CLS_NONE && alnum_c));

	// word memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			word_mem[len_q[ADDR_W-1:0]] <= byte_q;
		end
		rd_data_s1 <= word_mem[rd_addr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			class_q     <= CLS_NONE;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			mask_q      <= '0;
			byte_q      <= '0;
			eot_q       <= 1'b0;
			kind_q      <= KIND_INT;
			has_text_q  <= 1'b0;
			char_q      <= '0;
			end_q       <= 1'b0;
			trunc_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (emit_c) begin
				out_valid_q <= 1'b1;
			end else if (!token_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (byte_valid) begin
						byte_q  <= text_byte;
						eot_q   <= end_of_text;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (cont_c) begin
						if (room_c) begin
							len_q  <= len_q + LEN_W'(1);
							mask_q <= mask_q & step_mask_c;
						end else begin
							ovf_q <= 1'b1;
						end
						state_q <= eot_q ? ST_PREP : ST_IDLE;
					end else if (class_q != CLS_NONE) begin
						pend_q  <= 1'b1;
						state_q <= ST_PREP;
					end else if (alnum_c) begin
						class_q <= is_letter(byte_q) ? CLS_WORD : CLS_NUM;
						len_q   <= LEN_W'(1);
						ovf_q   <= 1'b0;
						mask_q  <= start_mask_c;
						state_q <= eot_q ? ST_PREP : ST_IDLE;
					end else if (is_punct(byte_q)) begin
						if (out_free_c) begin
							kind_q      <= punct_kind(byte_q);
							has_text_q  <= 1'b0;
							char_q      <= '0;
							end_q       <= 1'b1;
							trunc_q     <= 1'b0;
							last_q      <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PREP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free_c) begin
						if (kw_hit_c) begin
							kind_q     <= kw_idx_c;
							has_text_q <= 1'b0;
							char_q     <= '0;
							end_q      <= 1'b1;
							trunc_q    <= 1'b0;
							last_q     <= !more_c;
						end else begin
							kind_q     <= (class_q == CLS_NUM) ? KIND_INT : KIND_STRING;
							has_text_q <= 1'b1;
							char_q     <= rd_data_s1;
							end_q      <= last_c;
							trunc_q    <= ovf_q;
							last_q     <= last_c && !more_c;
						end
						if (kw_hit_c || last_c) begin
							class_q <= CLS_NONE;
							len_q   <= '0;
							ovf_q   <= 1'b0;
							pend_q  <= 1'b0;
							state_q <= pend_q ? ST_DECIDE : ST_IDLE;
						end else begin
							idx_q <= idx_q + ADDR_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign byte_stall  = state_q != ST_IDLE;
	assign token_valid = out_valid_q;
	assign token_kind  = kind_q;
	assign has_text    = has_text_q;
	assign text_char   = char_q;
	assign token_end   = end_q;
	assign truncated   = trunc_q;
	assign run_last    = last_q;

	`KTL_ASSERT_NOW(a_len_range, 1'b1, len_q <= LEN_W'(MAX_WORD), "word length beyond store")
	`KTL_ASSERT_NOW(a_empty_clear, class_q == CLS_NONE, len_q == '0 && !ovf_q, "empty word set")
	`KTL_ASSERT_NOW(a_ovf_full, ovf_q, len_q == LEN_W'(MAX_WORD), "overflow without full store")
	`KTL_ASSERT_NOW(a_text_kind, token_valid && has_text, token_kind == KIND_INT || token_kind == KIND_STRING, "text kind")
	`KTL_ASSERT_NEXT(a_accept_decide, byte_valid && !byte_stall, state_q == ST_DECIDE, "byte not decoded")

endmodule

// ===== sim/tb.sv =====
// testbench for keyword_token_lexer: directed table plus random text checked by a token predictor
`timescale 1ns / 1ps

module tb;
	import ktl_pkg::*;

	localparam int WORD_CAP   = MAX_WORD_DEF;
	localparam int QUIET_MAX  = 3000;
	localparam int HOLD_LEN   = 400;
	localparam int ITEM_GOAL  = 410;

	typedef struct packed {
		kind_t      kind;
		logic       has_txt;
		logic [7:0] ch;
		logic       tok_end;
		logic       trunc;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
		logic       typed;
		logic       one;
		kind_t      kind;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	logic [7:0] text_byte;
	logic end_of_text;
	logic token_valid;
	logic token_stall;
	logic [4:0] token_kind;
	logic has_text;
	logic [7:0] text_char;
	logic token_end;
	logic truncated;
	logic run_last;

	keyword_token_lexer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.has_text(has_text),
		.text_char(text_char),
		.token_end(token_end),
		.truncated(truncated),
		.run_last(run_last)
	);

	always #10 clk = ~clk;

	string kw_names [14] = '{"return", "fun", "var", "const", "continue", "break", "int",
		"string", "print", "println", "if", "else", "while", "for"};
	logic [7:0] punct_bytes [12] = '{"\"", "(", ")", "{", "}", ";", "+", "-", "*", "/",
		"=", "!"};

	// word being collected by the predictor
	logic [7:0]  word_buf [WORD_CAP];
	int          word_len;
	word_class_t word_cls;
	logic        word_ovf;

	tok_t step_toks[$];
	tok_t exp_tokens[$];

	int  mismatches = 0;
	int  live_items = 0;
	int  quiet_cycles = 0;
	bit  hold_go = 1'b0;
	bit  calm = 1'b0;

	function automatic bit alpha_byte(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit num_byte(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic void add_tok(input kind_t k, input logic h, input logic [7:0] c,
		input logic e, input logic t);
		tok_t r;
		r = '{k, h, c, e, t, 1'b0};
		step_toks.push_back(r);
	endfunction

	function automatic void clear_word();
		word_cls = CLS_NONE;
		word_len = 0;
		word_ovf = 1'b0;
	endfunction

	function automatic void store_char(input logic [7:0] b);
		if (word_len < WORD_CAP) begin
			word_buf[word_len] = b;
			word_len++;
		end else begin
			word_ovf = 1'b1;
		end
	endfunction

	function automatic void flush_word();
		int k;
		int i;
		bit hit;
		kind_t run_kind;
		if (word_cls == CLS_NONE)
			return;
		if (word_cls == CLS_WORD && !word_ovf) begin
			for (k = 0; k < 14; k++) begin
				if (kw_names[k].len() == word_len) begin
					hit = 1'b1;
					for (i = 0; i < word_len; i++)
						if (kw_names[k][i] != word_buf[i])
							hit = 1'b0;
					if (hit) begin
						add_tok(kind_t'(k), 1'b0, 8'h00, 1'b1, 1'b0);
						clear_word();
						return;
					end
				end
			end
		end
		run_kind = (word_cls == CLS_NUM) ? KIND_INT : KIND_STRING;
		for (i = 0; i < word_len; i++)
			add_tok(run_kind, 1'b1, word_buf[i], (i + 1 == word_len), word_ovf);
		clear_word();
	endfunction

	function automatic void lex_byte(input logic [7:0] b, input logic eot);
		tok_t r;
		step_toks.delete();
		if ((word_cls == CLS_WORD && (alpha_byte(b) || num_byte(b))) ||
				(word_cls == CLS_NUM && num_byte(b))) begin
			store_char(b);
		end else begin
			flush_word();
			if (alpha_byte(b)) begin
				word_cls = CLS_WORD;
				store_char(b);
			end else if (num_byte(b)) begin
				word_cls = CLS_NUM;
				store_char(b);
			end else begin
				case (b)
					"\"": add_tok(KIND_QUOTE, 1'b0, 8'h00, 1'b1, 1'b0);
					"(": add_tok(KIND_LPAREN, 1'b0, 8'h00, 1'b1, 1'b0);
					")": add_tok(KIND_RPAREN, 1'b0, 8'h00, 1'b1, 1'b0);
					"{": add_tok(KIND_LBRACE, 1'b0, 8'h00, 1'b1, 1'b0);
					"}": add_tok(KIND_RBRACE, 1'b0, 8'h00, 1'b1, 1'b0);
					";": add_tok(KIND_SEMI, 1'b0, 8'h00, 1'b1, 1'b0);
					"+": add_tok(KIND_PLUS, 1'b0, 8'h00, 1'b1, 1'b0);
					"-": add_tok(KIND_MINUS, 1'b0, 8'h00, 1'b1, 1'b0);
					"*": add_tok(KIND_TIMES, 1'b0, 8'h00, 1'b1, 1'b0);
					"/": add_tok(KIND_DIVIDE, 1'b0, 8'h00, 1'b1, 1'b0);
					"=": add_tok(KIND_EQUALS, 1'b0, 8'h00, 1'b1, 1'b0);
					"!": add_tok(KIND_NOT, 1'b0, 8'h00, 1'b1, 1'b0);
					default: ;
				endcase
			end
		end
		if (eot)
			flush_word();
		if (step_toks.size() != 0) begin
			r = step_toks[step_toks.size() - 1];
			r.last = 1'b1;
			step_toks[step_toks.size() - 1] = r;
		end
	endfunction

	task automatic offer(input logic [7:0] b, input logic eot);
		int unsigned gap;
		text_byte <= b;
		end_of_text <= eot;
		byte_valid <= 1'b1;
		do @(posedge clk); while (byte_stall);
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 17);
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic emit(input logic [7:0] b, input logic eot);
		lex_byte(b, eot);
		foreach (step_toks[i])
			exp_tokens.push_back(step_toks[i]);
		live_items++;
		offer(b, eot);
	endtask

	function automatic logic eot_roll();
		return $urandom_range(0, 39) == 0;
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'("a") + 8'($urandom_range(0, 25));
		return 8'("A") + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0") + 8'($urandom_range(0, 9));
	endfunction

	function automatic int unsigned rand_len();
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(14, 21);
		return $urandom_range(1, 8);
	endfunction

	// one keyword, word, number, symbol or junk byte, usually with a separator
	task automatic gen_phrase();
		int unsigned pick;
		int unsigned n;
		int unsigned i;
		string kw;
		pick = $urandom_range(0, 99);
		kw = kw_names[$urandom_range(0, 13)];
		if (pick < 30) begin
			for (i = 0; i < kw.len(); i++)
				emit(kw[i], eot_roll());
		end else if (pick < 40) begin
			n = $urandom_range(0, 1) ? kw.len() - 1 : kw.len();
			for (i = 0; i < n; i++)
				emit(kw[i], 1'b0);
			if (n == kw.len())
				emit($urandom_range(0, 1) ? rand_letter() : rand_digit(), eot_roll());
		end else if (pick < 58) begin
			n = rand_len();
			emit(rand_letter(), eot_roll());
			for (i = 1; i < n; i++)
				emit($urandom_range(0, 2) ? rand_letter() : rand_digit(), eot_roll());
		end else if (pick < 70) begin
			n = rand_len();
			for (i = 0; i < n; i++)
				emit(rand_digit(), eot_roll());
		end else if (pick < 85) begin
			emit(punct_bytes[$urandom_range(0, 11)], eot_roll());
		end else if (pick < 93) begin
			emit($urandom_range(0, 1) ? 8'h20 : 8'h0a, eot_roll());
		end else begin
			emit(8'($urandom_range(0, 255)), eot_roll());
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 2))
				0: emit(8'h20, eot_roll());
				1: emit(8'h0a, eot_roll());
				default: emit(punct_bytes[$urandom_range(0, 11)], eot_roll());
			endcase
		end
	endtask

	row_t plan [25] = '{
		'{"(", 1'b0, 1'b1, 1'b1, KIND_LPAREN},
		'{")", 1'b0, 1'b1, 1'b1, KIND_RPAREN},
		'{"{", 1'b0, 1'b1, 1'b1, KIND_LBRACE},
		'{"}", 1'b0, 1'b1, 1'b1, KIND_RBRACE},
		'{";", 1'b0, 1'b1, 1'b1, KIND_SEMI},
		'{"+", 1'b0, 1'b1, 1'b1, KIND_PLUS},
		'{"-", 1'b0, 1'b1, 1'b1, KIND_MINUS},
		'{"*", 1'b0, 1'b1, 1'b1, KIND_TIMES},
		'{"/", 1'b0, 1'b1, 1'b1, KIND_DIVIDE},
		'{"=", 1'b0, 1'b1, 1'b1, KIND_EQUALS},
		'{"!", 1'b0, 1'b1, 1'b1, KIND_NOT},
		'{"\"", 1'b0, 1'b1, 1'b1, KIND_QUOTE},
		'{8'h00, 1'b0, 1'b1, 1'b0, '0},
		'{8'hff, 1'b0, 1'b1, 1'b0, '0},
		'{" ", 1'b0, 1'b1, 1'b0, '0},
		'{"i", 1'b0, 1'b1, 1'b0, '0},
		'{"f", 1'b1, 1'b0, 1'b0, '0},
		'{"9", 1'b0, 1'b1, 1'b0, '0},
		'{"a", 1'b0, 1'b0, 1'b0, '0},
		'{8'h0a, 1'b1, 1'b0, 1'b0, '0},
		'{"f", 1'b0, 1'b0, 1'b0, '0},
		'{"o", 1'b0, 1'b0, 1'b0, '0},
		'{"r", 1'b0, 1'b0, 1'b0, '0},
		'{";", 1'b0, 1'b0, 1'b0, '0},
		'{"Z", 1'b1, 1'b0, 1'b0, '0}
	};

	// sender
	initial begin
		bit drained;
		drained = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		text_byte = 8'h00;
		end_of_text = 1'b0;
		clear_word();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[r]) begin
			lex_byte(plan[r].b, plan[r].eot);
			if (plan[r].typed) begin
				if (plan[r].one)
					exp_tokens.push_back('{plan[r].kind, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1});
			end else begin
				foreach (step_toks[i])
					exp_tokens.push_back(step_toks[i]);
			end
			live_items++;
			offer(plan[r].b, plan[r].eot);
		end
		while (live_items < ITEM_GOAL) begin
			if (live_items >= 150)
				hold_go = 1'b1;
			if (live_items >= 280 && !drained) begin
				drained = 1'b1;
				byte_valid <= 1'b0;
				while (exp_tokens.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			if (live_items >= 350)
				calm = 1'b1;
			gen_phrase();
		end
		byte_valid <= 1'b0;
		while (exp_tokens.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// receiver stalls
	initial begin
		bit held;
		int unsigned n;
		held = 1'b0;
		token_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				token_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				token_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 17);
				token_stall <= 1'b1;
				repeat (n) @(posedge clk);
				token_stall <= 1'b0;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		tok_t got;
		tok_t want;
		if (arst_n && token_valid && !token_stall) begin
			got = '{token_kind, has_text, text_char, token_end, truncated, run_last};
			if (exp_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: kind %0d text %0b/%h end %0b trunc %0b last %0b",
						got.kind, got.has_txt, got.ch, got.tok_end, got.trunc, got.last);
			end else begin
				want = exp_tokens.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: want kind %0d text %0b/%h end %0b trunc %0b last %0b",
							want.kind, want.has_txt, want.ch, want.tok_end, want.trunc, want.last);
						$display("          got  kind %0d text %0b/%h end %0b trunc %0b last %0b",
							got.kind, got.has_txt, got.ch, got.tok_end, got.trunc, got.last);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (token_valid && !token_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
